// ===== rtl/praoa_pkg.sv =====
// Shared types and constants for the photodiode ring angle-of-arrival block.
package praoa_pkg;

   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 3;
   localparam int RAD_K_W   = 24;

   localparam logic [15:0]        NOISE_MARGIN_RST = 16'd5;
   localparam logic [15:0]        PEAK_MIN_RST     = 16'd40;
   localparam logic signed [23:0] SLOPE_ONE_RST    = 24'sd4680;
   localparam logic signed [23:0] SLOPE_THREE_RST  = -24'sd3047;
   localparam logic [4:0]         MARGIN_LOW_RST   = 5'd8;
   localparam logic [4:0]         MARGIN_HIGH_RST  = 5'd8;

   // pi * 10000 / 180 with 16 fraction bits
   localparam logic [RAD_K_W-1:0] RAD_K     = 24'd11438190;
   localparam logic [15:0]        ANGLE_MAX = 16'd62832;

   typedef enum logic [1:0] {
      CMD_TABLE,
      CMD_NOISE_A,
      CMD_NOISE_B,
      CMD_MEAS
   } item_cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOISE_MARGIN,
      CSR_PEAK_MINIMUM,
      CSR_SLOPE_ONE,
      CSR_SLOPE_THREE,
      CSR_MARGIN_LOW,
      CSR_MARGIN_HIGH
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN_INIT,
      ST_SCAN,
      ST_CHECK,
      ST_FAIL,
      ST_LD_CCW,
      ST_LD_CW,
      ST_DIV_RATIO,
      ST_WAIT_RATIO,
      ST_SRCH_ADDR,
      ST_SRCH_CMP,
      ST_SECT,
      ST_DIV_PM,
      ST_WAIT_TMP,
      ST_RD_OFF,
      ST_DIV_SEC,
      ST_RD_LO,
      ST_DIV_SEC2,
      ST_WAIT_DEG,
      ST_ADD_M,
      ST_WRAP,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      seq_state_type step;
      logic          idle;
   } ctrl_cmd_type;

   typedef struct packed {
      logic meas_end;
      logic scan_last;
      logic peak_low;
      logic srch_hit;
      logic srch_last;
      logic sec_lo;
      logic sec_hi;
      logic div_done;
   } dp_status_type;

   typedef struct packed {
      logic [15:0] angle;
      logic        failed;
      logic [16:0] noise_threshold;
      logic        is_threshold_report;
   } rsp_type;

endpackage

// ===== rtl/praoa_ifs.sv =====
// Valid/ready channel interfaces for item and result transfers.
interface praoa_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [5:0]         index;
   logic [15:0]        sample;
   logic signed [31:0] table_word;
   logic               frame_end;

   modport source(output valid, cmd, index, sample, table_word, frame_end, input ready);
   modport sink(input valid, cmd, index, sample, table_word, frame_end, output ready);
endinterface

interface praoa_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] angle;
   logic        failed;
   logic [16:0] noise_threshold;
   logic        is_threshold_report;

   modport source(output valid, angle, failed, noise_threshold, is_threshold_report,
                  input ready);
   modport sink(input valid, angle, failed, noise_threshold, is_threshold_report,
                output ready);
endinterface

// ===== rtl/praoa_div.sv =====
// Bit-serial restoring Q divider: (num << FRAC_BITS) / den, truncating and saturating.
module praoa_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [33:0] num,
   input  logic signed [33:0] den,
   output logic               done,
   output logic signed [31:0] q
);
   localparam int OW  = 34;
   localparam int NW  = OW + FRAC_BITS;
   localparam int CNW = $clog2(NW + 1);

   logic           run_ff, fin_ff, done_ff;
   logic [CNW-1:0] cnt_ff;
   logic [NW-1:0]  dvd_ff;
   logic [OW-1:0]  dsr_ff, rem_ff;
   logic           neg_ff, zero_ff, nneg_ff;
   logic [31:0]    q_ff;

   logic [OW-1:0] num_mag, den_mag;
   logic [OW:0]   rem_s, rem_d;
   logic          ge, big;
   logic [31:0]   q_in;

   assign num_mag = num[OW-1] ? OW'(-num) : OW'(num);
   assign den_mag = den[OW-1] ? OW'(-den) : OW'(den);
   assign rem_s   = {rem_ff, dvd_ff[NW-1]};
   assign ge      = rem_s >= {1'b0, dsr_ff};
   assign rem_d   = rem_s - {1'b0, dsr_ff};

   always_comb begin
      big = neg_ff ? (dvd_ff > NW'(32'h8000_0000)) : (dvd_ff > NW'(32'h7FFF_FFFF));
      if (zero_ff) begin
         q_in = nneg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (neg_ff) begin
         q_in = big ? 32'h8000_0000 : 32'(NW'(0) - dvd_ff);
      end else begin
         q_in = big ? 32'h7FFF_FFFF : dvd_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= CNW'(NW);
            dvd_ff  <= {num_mag, {FRAC_BITS{1'b0}}};
            dsr_ff  <= den_mag;
            rem_ff  <= '0;
            neg_ff  <= num[OW-1] ^ den[OW-1];
            nneg_ff <= num[OW-1];
            zero_ff <= (den == '0);
         end else if (run_ff) begin
            dvd_ff <= {dvd_ff[NW-2:0], ge};
            rem_ff <= ge ? rem_d[OW-1:0] : rem_s[OW-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNW'(1)) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end else if (fin_ff) begin
            q_ff    <= q_in;
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign q    = q_ff;
endmodule

// ===== rtl/praoa_dp.sv =====
// Datapath: stores, threshold logic, calibration memory, divider and angle arithmetic.
module praoa_dp #(
   parameter int CHANNELS     = 12,
   parameter int TABLE_POINTS = 31,
   parameter int FRAC_BITS    = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             acc,
   input  praoa_pkg::item_cmd_type          item_cmd,
   input  logic [5:0]                       item_index,
   input  logic [15:0]                      item_sample,
   input  logic signed [31:0]               item_word,
   input  logic                             item_end,
   input  logic                             csr_wr_en,
   input  logic [praoa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [praoa_pkg::CSR_W-1:0]      csr_wdata,
   input  praoa_pkg::ctrl_cmd_type          ctl,
   output praoa_pkg::dp_status_type         sts,
   output logic                             push,
   output praoa_pkg::rsp_type               push_data
);
   import praoa_pkg::*;

   localparam int CW  = $clog2(CHANNELS);
   localparam int PW  = $clog2((CHANNELS > TABLE_POINTS + 1) ? CHANNELS : TABLE_POINTS + 1);
   localparam int MD  = TABLE_POINTS + 2 * CHANNELS;
   localparam int AW  = $clog2(MD);
   localparam int DW  = ((FRAC_BITS + 11 > 32) ? FRAC_BITS + 11 : 32) + 2;
   localparam int LW  = (DW - 1) / 2;
   localparam int MW  = DW - 1 + RAD_K_W;
   localparam int PRW = MW - FRAC_BITS - 16;
   localparam int MID = (TABLE_POINTS - 1) / 2 + 1;
   localparam logic [DW-1:0] ANG_STEP = DW'((64'd360 << FRAC_BITS) / CHANNELS);
   localparam logic [DW-1:0] FULL_CIRCLE = DW'(64'd360 << FRAC_BITS);

   // configuration
   logic [15:0]        margin_ff, pkmin_ff;
   logic signed [23:0] slope1_ff, slope3_ff;
   logic [4:0]         mlo_ff, mhi_ff;

   // stores
   logic [15:0]        base_ff [CHANNELS];
   logic [15:0]        sig_ff  [CHANNELS];
   logic [16:0]        thr_ff;
   logic               bopen_ff;
   logic signed [31:0] mem [MD];
   logic signed [31:0] mem_q;

   // angle working registers
   logic [PW-1:0]      ptr_ff, idx_ff;
   logic [CW-1:0]      m_ff, ccw_ff, cw_ff;
   logic [15:0]        pk_ff, vccw_ff, vcw_ff;
   logic signed [31:0] ratio_ff, hi_ff, tmp_ff;
   logic signed [DW-1:0] deg_ff;
   logic [MW-1:0]      acc_ff;

   // item handling
   logic               ch_ok, tbl_ok;
   logic [CW-1:0]      ch;
   logic [15:0]        base_rd;
   logic signed [16:0] diff;
   logic [16:0]        absd, thr_base, thr_b_new;
   logic               keep;

   assign ch_ok    = item_index < 6'(CHANNELS);
   assign tbl_ok   = {1'b0, item_index} < 7'(MD);
   assign ch       = item_index[CW-1:0];
   assign base_rd  = base_ff[ch];
   assign diff     = $signed({1'b0, item_sample}) - $signed({1'b0, base_rd});
   assign absd     = diff[16] ? 17'(-diff) : 17'(diff);
   assign thr_base = bopen_ff ? thr_ff : {1'b0, margin_ff};
   assign thr_b_new = (ch_ok && absd > thr_base) ? 17'(absd + {1'b0, margin_ff}) : thr_base;
   assign keep     = $signed({diff[16], diff}) > $signed({1'b0, thr_ff});

   // sequencer-side signals
   logic [CW-1:0]      sig_addr;
   logic [15:0]        sig_rd;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               div_start, div_done;
   logic signed [33:0] div_num, div_den;
   logic signed [31:0] div_q;
   logic signed [DW-1:0] mid_off;
   logic [DW-1:0]      m_prod;
   logic [MW-1:0]      lo_prod, hi_prod;
   logic [PRW-1:0]     prod;
   logic [15:0]        angle_sat;

   assign sig_rd  = sig_ff[sig_addr];
   assign mid_off = (DW'(idx_ff) - DW'(MID)) <<< FRAC_BITS;
   assign m_prod  = DW'(m_ff) * ANG_STEP;
   assign lo_prod = MW'(deg_ff[LW-1:0]) * MW'(RAD_K);
   assign hi_prod = MW'(deg_ff[DW-2:LW]) * MW'(RAD_K);
   assign prod    = acc_ff[MW-1:FRAC_BITS+16];
   assign angle_sat = (prod > PRW'(ANGLE_MAX)) ? ANGLE_MAX : prod[15:0];

   always_comb begin
      sig_addr  = '0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (ctl.step)
         ST_SCAN:   sig_addr = ptr_ff[CW-1:0];
         ST_LD_CCW: sig_addr = ccw_ff;
         ST_LD_CW:  sig_addr = cw_ff;
         ST_SRCH_ADDR: begin
            rd_en   = 1'b1;
            rd_addr = AW'(ptr_ff);
         end
         ST_RD_LO: begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_ff - 1'b1);
         end
         ST_RD_OFF: begin
            rd_en   = 1'b1;
            rd_addr = sts.sec_lo ? AW'(TABLE_POINTS) + AW'(ccw_ff)
                                 : AW'(TABLE_POINTS + CHANNELS) + AW'(ccw_ff);
         end
         ST_DIV_RATIO: begin
            div_start = 1'b1;
            div_num   = 34'(vcw_ff);
            div_den   = 34'(vccw_ff);
         end
         ST_DIV_PM: begin
            div_start = 1'b1;
            div_num   = 34'(pk_ff);
            div_den   = sts.sec_lo ? 34'(vccw_ff) : 34'(vcw_ff);
         end
         ST_DIV_SEC: begin
            div_start = 1'b1;
            div_num   = 34'(tmp_ff) - 34'(mem_q);
            div_den   = sts.sec_lo ? 34'(slope1_ff) : 34'(slope3_ff);
         end
         ST_DIV_SEC2: begin
            div_start = 1'b1;
            div_num   = 34'(ratio_ff) - 34'(mem_q);
            div_den   = 34'(hi_ff) - 34'(mem_q);
         end
         default: ;
      endcase
   end

   praoa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .q     (div_q)
   );

   always_comb begin
      sts.meas_end  = acc && item_cmd == CMD_MEAS && item_end;
      sts.scan_last = ptr_ff == PW'(CHANNELS - 1);
      sts.peak_low  = pk_ff < pkmin_ff;
      sts.srch_hit  = ratio_ff < mem_q;
      sts.srch_last = ptr_ff == PW'(TABLE_POINTS - 1);
      sts.sec_lo    = 7'(idx_ff) < 7'(mlo_ff);
      sts.sec_hi    = (7'(idx_ff) + 7'(mhi_ff)) > 7'(TABLE_POINTS - 1);
      sts.div_done  = div_done;
   end

   always_comb begin
      push      = 1'b0;
      push_data = '0;
      if (acc && item_cmd == CMD_NOISE_B && item_end) begin
         push                          = 1'b1;
         push_data.noise_threshold     = thr_b_new;
         push_data.is_threshold_report = 1'b1;
      end else if (ctl.step == ST_FAIL) begin
         push                      = 1'b1;
         push_data.failed          = 1'b1;
         push_data.noise_threshold = thr_ff;
      end else if (ctl.step == ST_EMIT) begin
         push                      = 1'b1;
         push_data.angle           = deg_ff[DW-1] ? 16'd0 : angle_sat;
         push_data.noise_threshold = thr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= NOISE_MARGIN_RST;
         pkmin_ff  <= PEAK_MIN_RST;
         slope1_ff <= SLOPE_ONE_RST;
         slope3_ff <= SLOPE_THREE_RST;
         mlo_ff    <= MARGIN_LOW_RST;
         mhi_ff    <= MARGIN_HIGH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NOISE_MARGIN: margin_ff <= csr_wdata[15:0];
            CSR_PEAK_MINIMUM: pkmin_ff  <= csr_wdata[15:0];
            CSR_SLOPE_ONE:    slope1_ff <= $signed(csr_wdata);
            CSR_SLOPE_THREE:  slope3_ff <= $signed(csr_wdata);
            CSR_MARGIN_LOW:   mlo_ff    <= csr_wdata[4:0];
            CSR_MARGIN_HIGH:  mhi_ff    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= {1'b0, NOISE_MARGIN_RST};
         bopen_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) base_ff[i] <= '0;
      end else if (acc) begin
         bopen_ff <= (item_cmd == CMD_NOISE_B) && !item_end;
         case (item_cmd)
            CMD_NOISE_A: if (ch_ok) base_ff[ch] <= item_sample;
            CMD_NOISE_B: thr_ff <= thr_b_new;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (acc && item_cmd == CMD_MEAS && ch_ok) begin
         sig_ff[ch] <= keep ? diff[15:0] : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && item_cmd == CMD_TABLE && tbl_ok) begin
         mem[AW'(item_index)] <= item_word;
      end
      if (rd_en) begin
         mem_q <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.step)
         ST_SCAN_INIT: begin
            pk_ff  <= sig_rd;
            m_ff   <= '0;
            ptr_ff <= PW'(1);
         end
         ST_SCAN: begin
            if (sig_rd > pk_ff) begin
               pk_ff <= sig_rd;
               m_ff  <= ptr_ff[CW-1:0];
            end
            ptr_ff <= ptr_ff + 1'b1;
         end
         ST_CHECK: begin
            ccw_ff <= (m_ff == '0) ? CW'(CHANNELS - 1) : m_ff - 1'b1;
            cw_ff  <= (m_ff == CW'(CHANNELS - 1)) ? '0 : m_ff + 1'b1;
         end
         ST_LD_CCW:    vccw_ff <= sig_rd;
         ST_LD_CW:     vcw_ff  <= sig_rd;
         ST_DIV_RATIO: ptr_ff  <= PW'(1);
         ST_WAIT_RATIO: if (div_done) ratio_ff <= div_q;
         ST_SRCH_CMP: begin
            if (sts.srch_hit) begin
               idx_ff <= ptr_ff;
               hi_ff  <= mem_q;
            end else if (sts.srch_last) begin
               idx_ff <= PW'(TABLE_POINTS);
            end else begin
               ptr_ff <= ptr_ff + 1'b1;
            end
         end
         ST_WAIT_TMP: if (div_done) tmp_ff <= div_q;
         ST_WAIT_DEG: begin
            if (div_done) begin
               deg_ff <= DW'(div_q) + ((sts.sec_lo || sts.sec_hi) ? '0 : mid_off);
            end
         end
         ST_ADD_M:  deg_ff <= deg_ff + $signed(m_prod);
         ST_WRAP:   if (deg_ff[DW-1]) deg_ff <= deg_ff + $signed(FULL_CIRCLE);
         ST_MUL_LO: acc_ff <= lo_prod;
         ST_MUL_HI: acc_ff <= acc_ff + (hi_prod << LW);
         default: ;
      endcase
   end
endmodule

// ===== rtl/praoa_ctrl.sv =====
// Sequencer for the frame-end angle computation.
module praoa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  praoa_pkg::dp_status_type sts,
   output praoa_pkg::ctrl_cmd_type  ctl
);
   import praoa_pkg::*;

   seq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (sts.meas_end) state_in = ST_SCAN_INIT;
         ST_SCAN_INIT:  state_in = ST_SCAN;
         ST_SCAN:       if (sts.scan_last) state_in = ST_CHECK;
         ST_CHECK:      state_in = sts.peak_low ? ST_FAIL : ST_LD_CCW;
         ST_FAIL:       state_in = ST_IDLE;
         ST_LD_CCW:     state_in = ST_LD_CW;
         ST_LD_CW:      state_in = ST_DIV_RATIO;
         ST_DIV_RATIO:  state_in = ST_WAIT_RATIO;
         ST_WAIT_RATIO: if (sts.div_done) state_in = ST_SRCH_ADDR;
         ST_SRCH_ADDR:  state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            state_in = (sts.srch_hit || sts.srch_last) ? ST_SECT : ST_SRCH_ADDR;
         end
         ST_SECT:       state_in = (sts.sec_lo || sts.sec_hi) ? ST_DIV_PM : ST_RD_LO;
         ST_DIV_PM:     state_in = ST_WAIT_TMP;
         ST_WAIT_TMP:   if (sts.div_done) state_in = ST_RD_OFF;
         ST_RD_OFF:     state_in = ST_DIV_SEC;
         ST_DIV_SEC:    state_in = ST_WAIT_DEG;
         ST_RD_LO:      state_in = ST_DIV_SEC2;
         ST_DIV_SEC2:   state_in = ST_WAIT_DEG;
         ST_WAIT_DEG:   if (sts.div_done) state_in = ST_ADD_M;
         ST_ADD_M:      state_in = ST_WRAP;
         ST_WRAP:       state_in = ST_MUL_LO;
         ST_MUL_LO:     state_in = ST_MUL_HI;
         ST_MUL_HI:     state_in = ST_EMIT;
         ST_EMIT:       state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
      ctl.step = state_ff;
      ctl.idle = (state_ff == ST_IDLE);
   end
endmodule

// ===== rtl/praoa_outq.sv =====
// Two-entry result queue driving the result channel.
module praoa_outq (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  praoa_pkg::rsp_type push_data,
   output logic               full,
   praoa_rsp_if.source        rsp_ch
);
   import praoa_pkg::*;

   logic    head_v_ff, tail_v_ff;
   rsp_type head_ff, tail_ff;
   logic    pop;

   assign pop = head_v_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         tail_v_ff <= 1'b0;
      end else if (pop) begin
         if (tail_v_ff) begin
            head_ff   <= tail_ff;
            tail_ff   <= push_data;
            tail_v_ff <= push;
         end else begin
            head_ff   <= push_data;
            head_v_ff <= push;
         end
      end else if (!head_v_ff) begin
         head_ff   <= push_data;
         head_v_ff <= push;
      end else if (push) begin
         tail_ff   <= push_data;
         tail_v_ff <= 1'b1;
      end
   end

   assign full                       = tail_v_ff;
   assign rsp_ch.valid               = head_v_ff;
   assign rsp_ch.angle               = head_ff.angle;
   assign rsp_ch.failed              = head_ff.failed;
   assign rsp_ch.noise_threshold     = head_ff.noise_threshold;
   assign rsp_ch.is_threshold_report = head_ff.is_threshold_report;
endmodule

// ===== rtl/photodiode_ring_angle_of_arrival.sv =====
// Top level of the photodiode ring angle-of-arrival estimator.
// Table words, noise samples and measurement samples that do not end a
// measurement frame are taken one per cycle while the result queue has room,
// and a noise frame B end issues its threshold report in the same cycle that
// it is taken. A measurement frame end runs the angle sequence and holds off
// new items until the sequence is done. The time is set by the peak scan over
// the channels, the table walk through the entries, and up to three passes
// through the bit-serial divider (one quotient bit per cycle). An angle from
// the middle section needs two divider passes. A failed peak check returns
// after the scan. Results go into a two-entry queue, so new items are taken
// while a result waits for transfer.
module photodiode_ring_angle_of_arrival #(
   parameter int CHANNELS     = 12,
   parameter int TABLE_POINTS = 31,
   parameter int FRAC_BITS    = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   praoa_req_if.sink                       req_ch,
   praoa_rsp_if.source                     rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [praoa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [praoa_pkg::CSR_W-1:0]     csr_wdata
);
   import praoa_pkg::*;

   ctrl_cmd_type  ctl;
   dp_status_type sts;
   rsp_type       push_data;
   logic          push, q_full, acc;

   assign req_ch.ready = ctl.idle && !q_full;
   assign acc          = req_ch.valid && req_ch.ready;

   praoa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   praoa_dp #(
      .CHANNELS     (CHANNELS),
      .TABLE_POINTS (TABLE_POINTS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .acc         (acc),
      .item_cmd    (item_cmd_type'(req_ch.cmd)),
      .item_index  (req_ch.index),
      .item_sample (req_ch.sample),
      .item_word   (req_ch.table_word),
      .item_end    (req_ch.frame_end),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .ctl         (ctl),
      .sts         (sts),
      .push        (push),
      .push_data   (push_data)
   );

   praoa_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .rsp_ch    (rsp_ch)
   );
endmodule

// ===== rtl/praoa_chk.sv =====
// Port-level assertions for the angle-of-arrival block, bound to the top level.
module praoa_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_angle,
   input logic        rsp_failed,
   input logic [16:0] rsp_thr,
   input logic        rsp_report
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle) && $stable(rsp_failed)
         && $stable(rsp_thr) && $stable(rsp_report))
      else $error("result changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_angle == 16'd0 && !rsp_report)
      else $error("failed result carries an angle");

   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report |-> rsp_angle == 16'd0 && !rsp_failed)
      else $error("threshold report carries angle or fail");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle <= 16'd62832)
      else $error("angle above full circle");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind photodiode_ring_angle_of_arrival praoa_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_angle  (rsp_ch.angle),
   .rsp_failed (rsp_ch.failed),
   .rsp_thr    (rsp_ch.noise_threshold),
   .rsp_report (rsp_ch.is_threshold_report)
);
